[rtl/rvc_pkg.sv]
// rvc_pkg: shared codes, opcodes and request structs for the RV32I subset core.
// No dependencies; imported by every module of the core.
`default_nettype none

package rvc_pkg;

    // item selector codes
    localparam logic [1:0] FUNC_EXEC    = 2'd0;
    localparam logic [1:0] FUNC_PRELOAD = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    localparam logic [6:0] OP_R      = 7'h33;
    localparam logic [6:0] OP_I      = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    localparam logic [6:0] F7_ADD = 7'h00;
    localparam logic [6:0] F7_SUB = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;

    // decoded result of one instruction
    typedef struct packed {
        logic        halt_word;
        logic [31:0] next_pc;
        logic        rd_wr;     // writes a register other than x0
        logic [4:0]  rd;
        logic [31:0] value;
        logic        load;
        logic        store;
        logic [31:0] mem_addr;
    } t_exec_res;

    // data memory request, word or single byte
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic        word;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_dmem_req;

endpackage

`default_nettype wire

[rtl/rvc_in_if.sv]
// rvc_in_if: request channel of the core, valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface rvc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] instruction;
    logic [9:0]  mem_address;
    logic [7:0]  mem_byte;

    modport source (output valid, func, instruction, mem_address, mem_byte, input ready);
    modport sink   (input valid, func, instruction, mem_address, mem_byte, output ready);
endinterface

`default_nettype wire

[rtl/rvc_out_if.sv]
// rvc_out_if: result channel of the core, valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface rvc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] executed_pc;
    logic [31:0] next_pc;
    logic        is_halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [7:0]  read_byte;

    modport source (output valid, executed_pc, next_pc, is_halted, reg_written, reg_index,
                    reg_value, read_byte, input ready);
    modport sink   (input valid, executed_pc, next_pc, is_halted, reg_written, reg_index,
                    reg_value, read_byte, output ready);
endinterface

`default_nettype wire

[rtl/rvc_exec.sv]
// rvc_exec: instruction decode, ALU, branch and jump target logic.
// Depends on rvc_pkg.
`default_nettype none

module rvc_exec
    import rvc_pkg::*;
(
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_pc,
    input  wire logic [31:0] i_op_a,
    input  wire logic [31:0] i_op_b,
    output t_exec_res        o_res
);

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] alu_b;
    logic [31:0] alu_out;
    logic [31:0] pc_plus4;
    logic        take;
    logic        wants;

    assign op = i_instruction[6:0];
    assign rd = i_instruction[11:7];
    assign f3 = i_instruction[14:12];
    assign f7 = i_instruction[31:25];

    assign imm_i = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign imm_s = {{20{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};
    assign imm_b = {{19{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                    i_instruction[30:25], i_instruction[11:8], 1'b0};
    assign imm_j = {{11{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                    i_instruction[20], i_instruction[30:21], 1'b0};

    assign alu_b    = (op == OP_R) ? i_op_b : imm_i;
    assign pc_plus4 = i_pc + 32'd4;

    always_comb begin
        unique case (f3)
            F3_ADD: begin
                // funct7 only matters for register-register ops
                if (op != OP_R || f7 == F7_ADD) begin
                    alu_out = i_op_a + alu_b;
                end else if (f7 == F7_SUB) begin
                    alu_out = i_op_a - alu_b;
                end else begin
                    alu_out = '0;
                end
            end
            F3_XOR:  alu_out = i_op_a ^ alu_b;
            F3_OR:   alu_out = i_op_a | alu_b;
            F3_AND:  alu_out = i_op_a & alu_b;
            default: alu_out = '0;
        endcase
    end

    always_comb begin
        unique case (f3)
            F3_BEQ:  take = (i_op_a == i_op_b);
            F3_BNE:  take = (i_op_a != i_op_b);
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        o_res           = '0;
        o_res.halt_word = (i_instruction == HALT_WORD);
        o_res.next_pc   = pc_plus4;
        o_res.rd        = rd;
        o_res.mem_addr  = i_op_a + ((op == OP_STORE) ? imm_s : imm_i);
        wants           = 1'b0;
        unique case (op)
            OP_R, OP_I: begin
                wants       = 1'b1;
                o_res.value = alu_out;
            end
            OP_LOAD: begin
                wants      = 1'b1;
                o_res.load = 1'b1;
            end
            OP_STORE: begin
                o_res.store = 1'b1;
            end
            OP_BRANCH: begin
                if (take) begin
                    o_res.next_pc = i_pc + imm_b;
                end
            end
            OP_JAL: begin
                wants         = 1'b1;
                o_res.value   = pc_plus4;
                o_res.next_pc = i_pc + imm_j;
            end
            default: ;
        endcase
        o_res.rd_wr = wants && (rd != 5'd0);
    end

endmodule

`default_nettype wire

[rtl/rvc_dmem.sv]
// rvc_dmem: byte data memory in four byte lanes, word and byte access, registered read,
// zero-fill sweep after reset. Depends on rvc_pkg.
`default_nettype none

module rvc_dmem
    import rvc_pkg::*;
#(
    parameter int MEM_BYTES = 1024   // power of two, at least 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dmem_req   i_req,
    output logic [31:0]      o_rdata,
    output logic             o_busy
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = AW - 2;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic          r_clr_busy;
    logic [RW-1:0] r_clr_row;
    logic [1:0]    r_off;
    logic [1:0]    off;
    logic [RW-1:0] base_row;
    logic [7:0]    lane_q [4];

    assign off      = i_req.addr[1:0];
    assign base_row = i_req.addr[AW-1:2];
    assign o_busy   = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + RW'(1);
            if (r_clr_row == LAST_ROW) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_off <= off;
        end
    end

    for (genvar L = 0; L < 4; L++) begin : g_lane
        logic [7:0]    mem [ROWS];
        logic [7:0]    r_q;
        logic [1:0]    lane_id;
        logic [1:0]    byte_sel;   // which byte of the word lands in this lane
        logic [RW-1:0] row;
        logic          we;

        assign lane_id  = 2'(L);
        assign byte_sel = lane_id - off;
        assign row      = base_row + RW'(lane_id < off);
        assign we       = i_req.wr_en && (i_req.word || byte_sel == 2'd0);

        always_ff @(posedge i_clk) begin
            if (r_clr_busy) begin
                mem[r_clr_row] <= '0;
            end else if (we) begin
                mem[row] <= i_req.wdata[8*byte_sel +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_req.rd_en) begin
                r_q <= mem[row];
            end
        end

        assign lane_q[L] = r_q;
    end

    // rotate lanes back into byte order; a byte read comes out in [7:0]
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = lane_q[2'(r_off + 2'(i))];
        end
    end

endmodule

`default_nettype wire

[rtl/rv32i_subset_single_cycle_core_top.sv]
// rv32i_subset_single_cycle_core_top: RV32I subset core, execute stage plus result stage.
// Depends on rvc_pkg, rvc_in_if, rvc_out_if, rvc_exec, rvc_dmem.
//
//  channel  dir  handshake        payload
//  i_in     in   valid / ready    func, instruction, mem_address, mem_byte
//  o_out    out  valid / ready    executed_pc, next_pc, is_halted, reg_written,
//                                 reg_index, reg_value, read_byte
//
// One request per cycle sustained while o_out is not stalled; a result passes through the
// input register, then execute into the result register (load data comes from the
// registered memory read), where a stalled o_out holds it.
// Register and load results are forwarded from the result stage, so no bubbles.
// After reset the data memory is zero-filled row by row with i_in.ready low.
// A stalled o_out holds both stages; outside the zero-fill, i_in.ready drops only when
// both are full and o_out.ready is low.
`default_nettype none

module rv32i_subset_single_cycle_core_top
    import rvc_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rvc_in_if.sink     i_in,
    rvc_out_if.source  o_out
);

    // architectural state
    logic [31:0] r_pc;
    logic        r_halted;
    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;

    // execute stage
    logic        r_s1_valid;
    logic [1:0]  r_s1_func;
    logic [31:0] r_s1_ins;
    logic [9:0]  r_s1_maddr;
    logic [7:0]  r_s1_mbyte;
    logic [31:0] r_a_data;
    logic        r_a_ok;
    logic [31:0] r_b_data;
    logic        r_b_ok;

    // result stage
    logic        r_s2_valid;
    logic [31:0] r_s2_epc;
    logic [31:0] r_s2_npc;
    logic        r_s2_halt;
    logic        r_s2_wr;
    logic [4:0]  r_s2_rd;
    logic [31:0] r_s2_val;
    logic        r_s2_load;
    logic        r_s2_rb;

    logic        adv;
    logic        s1_fire;
    logic        in_fire;
    logic        rf_we;
    logic        dmem_busy;
    logic [31:0] dmem_rdata;
    logic [31:0] s2_value;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  in_rs1;
    logic [4:0]  in_rs2;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        is_exec;
    logic        run;
    logic        halt_now;
    logic [31:0] n_pc;
    logic        n_halted;
    t_exec_res   ex;
    t_dmem_req   dreq;

    assign adv     = !r_s2_valid || o_out.ready;
    assign s1_fire = r_s1_valid && adv;
    assign i_in.ready = !dmem_busy && (!r_s1_valid || adv);
    assign in_fire = i_in.valid && i_in.ready;
    assign rf_we   = r_s2_valid && o_out.ready && r_s2_wr;

    assign s2_value = r_s2_load ? dmem_rdata : r_s2_val;

    // register file: read on request, write when a result leaves
    assign in_rs1 = i_in.instruction[19:15];
    assign in_rs2 = i_in.instruction[24:20];

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[r_s2_rd] <= s2_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[r_s2_rd] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func  <= i_in.func;
            r_s1_ins   <= i_in.instruction;
            r_s1_maddr <= i_in.mem_address;
            r_s1_mbyte <= i_in.mem_byte;
            // bypass a write landing at the same edge
            if (rf_we && r_s2_rd == in_rs1) begin
                r_a_data <= s2_value;
                r_a_ok   <= 1'b1;
            end else begin
                r_a_data <= r_rf[in_rs1];
                r_a_ok   <= r_rf_vld[in_rs1];
            end
            if (rf_we && r_s2_rd == in_rs2) begin
                r_b_data <= s2_value;
                r_b_ok   <= 1'b1;
            end else begin
                r_b_data <= r_rf[in_rs2];
                r_b_ok   <= r_rf_vld[in_rs2];
            end
        end
    end

    // operands, with forwarding from the result stage
    assign rs1 = r_s1_ins[19:15];
    assign rs2 = r_s1_ins[24:20];

    always_comb begin
        if (r_s2_valid && r_s2_wr && r_s2_rd == rs1) begin
            op_a = s2_value;
        end else begin
            op_a = r_a_ok ? r_a_data : '0;
        end
        if (r_s2_valid && r_s2_wr && r_s2_rd == rs2) begin
            op_b = s2_value;
        end else begin
            op_b = r_b_ok ? r_b_data : '0;
        end
    end

    rvc_exec u_exec (
        .i_instruction (r_s1_ins),
        .i_pc          (r_pc),
        .i_op_a        (op_a),
        .i_op_b        (op_b),
        .o_res         (ex)
    );

    assign is_exec  = (r_s1_func == FUNC_EXEC) && !r_halted;
    assign halt_now = is_exec && ex.halt_word;
    assign run      = is_exec && !ex.halt_word;
    assign n_pc     = run ? ex.next_pc : r_pc;
    assign n_halted = r_halted || halt_now;

    always_comb begin
        dreq.rd_en = s1_fire && ((run && ex.load) || r_s1_func == FUNC_READ);
        dreq.wr_en = s1_fire && ((run && ex.store) || r_s1_func == FUNC_PRELOAD);
        dreq.word  = run;
        dreq.addr  = run ? ex.mem_addr : {22'd0, r_s1_maddr};
        dreq.wdata = run ? op_b : {24'd0, r_s1_mbyte};
    end

    rvc_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_rdata (dmem_rdata),
        .o_busy  (dmem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pc       <= '0;
            r_halted   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_pc     <= n_pc;
                r_halted <= n_halted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_epc  <= r_pc;
            r_s2_npc  <= n_pc;
            r_s2_halt <= n_halted;
            r_s2_wr   <= run && ex.rd_wr;
            r_s2_rd   <= (run && ex.rd_wr) ? ex.rd : 5'd0;
            r_s2_val  <= (run && ex.rd_wr) ? ex.value : '0;
            r_s2_load <= run && ex.rd_wr && ex.load;
            r_s2_rb   <= (r_s1_func == FUNC_READ);
        end
    end

    assign o_out.valid       = r_s2_valid;
    assign o_out.executed_pc = r_s2_epc;
    assign o_out.next_pc     = r_s2_npc;
    assign o_out.is_halted   = r_s2_halt;
    assign o_out.reg_written = r_s2_wr;
    assign o_out.reg_index   = r_s2_rd;
    assign o_out.reg_value   = s2_value;
    assign o_out.read_byte   = r_s2_rb ? dmem_rdata[7:0] : 8'd0;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Testbench for the RV32I subset core: directed and random requests, with an in-bench
// model of the core state that checks every retired result in order.
// Depends on rvc_pkg, rvc_in_if, rvc_out_if and rv32i_subset_single_cycle_core_top.
module testbench
    import rvc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = 1024;
    localparam int RANDOM_REQS = 1120;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [6:0] OP_UNKNOWN = 7'h0B;
    localparam logic [6:0] F7_MUL = 7'h01;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_SRL = 3'd5;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [11:0] ALU_F3S = {F3_AND, F3_OR, F3_XOR, F3_ADD};

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] instruction;
        logic [9:0]  mem_address;
        logic [7:0]  mem_byte;
    } core_req_t;

    typedef struct packed {
        logic [31:0] executed_pc;
        logic [31:0] next_pc;
        logic        is_halted;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [7:0]  read_byte;
    } retire_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rvc_in_if  in_if ();
    rvc_out_if out_if ();

    rv32i_subset_single_cycle_core_top #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // model of the architectural state
    logic [31:0] core_pc;
    logic [31:0] gpr [32];
    logic [7:0]  dmem [MEM_BYTES];
    logic        core_halted;

    core_req_t req_q [$];
    retire_t   retire_q [$];
    core_req_t cur_req;

    int   accepted_cnt = 0;
    int   retired_cnt = 0;
    int   err_cnt = 0;
    int   tx_gap = 0;
    int   tx_quiet = 0;
    int   rx_stall = 0;
    int   rx_quiet = 0;
    logic hold_off = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int mem_idx(logic [31:0] addr);
        return int'(addr % 32'(MEM_BYTES));
    endfunction

    function automatic logic [31:0] alu_result(logic [2:0] f3, logic [6:0] f7,
                                               logic [31:0] a, logic [31:0] b, logic is_r);
        case (f3)
            F3_ADD: begin
                if (!is_r || f7 == F7_ADD) return a + b;
                if (f7 == F7_SUB) return a - b;
                return '0;
            end
            F3_XOR: return a ^ b;
            F3_OR:  return a | b;
            F3_AND: return a & b;
            default: return '0;
        endcase
    endfunction

    // apply one request to the model state, return what the core should report
    function automatic retire_t retire(core_req_t r);
        retire_t     res;
        logic [31:0] ins, a, b, immi, imms, immb, immj, val, addr;
        logic [6:0]  op, f7;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic        wants, take;
        res = '0;
        ins = r.instruction;
        res.executed_pc = core_pc;
        res.next_pc = core_pc;
        case (r.func)
            FUNC_PRELOAD: dmem[mem_idx(32'(r.mem_address))] = r.mem_byte;
            FUNC_READ: res.read_byte = dmem[mem_idx(32'(r.mem_address))];
            FUNC_EXEC: begin
                if (core_halted) begin
                    // nothing changes
                end else if (ins == HALT_WORD) begin
                    core_halted = 1'b1;
                end else begin
                    op = ins[6:0];
                    rd = ins[11:7];
                    f3 = ins[14:12];
                    f7 = ins[31:25];
                    a = gpr[ins[19:15]];
                    b = gpr[ins[24:20]];
                    immi = {{20{ins[31]}}, ins[31:20]};
                    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                    wants = 1'b0;
                    val = '0;
                    res.next_pc = core_pc + 32'd4;
                    case (op)
                        OP_R: begin
                            val = alu_result(f3, f7, a, b, 1'b1);
                            wants = 1'b1;
                        end
                        OP_I: begin
                            val = alu_result(f3, F7_ADD, a, immi, 1'b0);
                            wants = 1'b1;
                        end
                        OP_LOAD: begin
                            addr = a + immi;
                            for (int i = 0; i < 4; i++)
                                val[8*i +: 8] = dmem[mem_idx(addr + 32'(i))];
                            wants = 1'b1;
                        end
                        OP_STORE: begin
                            addr = a + imms;
                            for (int i = 0; i < 4; i++)
                                dmem[mem_idx(addr + 32'(i))] = b[8*i +: 8];
                        end
                        OP_BRANCH: begin
                            take = (f3 == F3_BEQ) ? (a == b) : (f3 == F3_BNE) ? (a != b) : 1'b0;
                            if (take) res.next_pc = core_pc + immb;
                        end
                        OP_JAL: begin
                            val = core_pc + 32'd4;
                            wants = 1'b1;
                            res.next_pc = core_pc + immj;
                        end
                        default: ;
                    endcase
                    if (wants && rd != 5'd0) begin
                        gpr[rd] = val;
                        res.reg_written = 1'b1;
                        res.reg_index = rd;
                        res.reg_value = val;
                    end
                    core_pc = res.next_pc;
                end
            end
            default: ;
        endcase
        res.is_halted = core_halted;
        return res;
    endfunction

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_R};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // mostly a small register window so results feed later instructions
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    // idle length: mostly short, a few long, with occasional stretches of none
    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) quiet = $urandom_range(20, 100);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_exec(logic [31:0] ins);
        req_q.push_back('{FUNC_EXEC, ins, 10'($urandom), 8'($urandom)});
    endtask

    task automatic queue_mem(logic [1:0] func, logic [9:0] addr, logic [7:0] data);
        req_q.push_back('{func, 32'($urandom), addr, data});
    endtask

    task automatic flag_error(string msg);
        if (err_cnt < 100) $display("ERROR at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %h, expected %h",
                                 retired_cnt, name, got, want));
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                retire_q.push_back(retire(cur_req));
                accepted_cnt++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.func <= cur_req.func;
                    in_if.instruction <= cur_req.instruction;
                    in_if.mem_address <= cur_req.mem_address;
                    in_if.mem_byte <= cur_req.mem_byte;
                    // keep offering back to back while the receiver is held off
                    tx_gap = hold_off ? 0 : idle_len(tx_quiet);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge i_clk) begin
        retire_t got;
        retire_t want;
        if (out_if.valid && out_if.ready) begin
            got.executed_pc = out_if.executed_pc;
            got.next_pc = out_if.next_pc;
            got.is_halted = out_if.is_halted;
            got.reg_written = out_if.reg_written;
            got.reg_index = out_if.reg_index;
            got.reg_value = out_if.reg_value;
            got.read_byte = out_if.read_byte;
            if (retire_q.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected", retired_cnt));
            end else begin
                want = retire_q.pop_front();
                check_field("executed_pc", got.executed_pc, want.executed_pc);
                check_field("next_pc", got.next_pc, want.next_pc);
                check_field("is_halted", 32'(got.is_halted), 32'(want.is_halted));
                check_field("reg_written", 32'(got.reg_written), 32'(want.reg_written));
                check_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
                check_field("reg_value", got.reg_value, want.reg_value);
                check_field("read_byte", 32'(got.read_byte), 32'(want.read_byte));
            end
            retired_cnt++;
        end
        if (!i_rst_n || hold_off) begin
            out_if.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            rx_stall = idle_len(rx_quiet);
        end
    end

    // long receiver hold-off so both stages fill and the input stalls
    initial begin
        wait (accepted_cnt >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          n_total;
        int          sel;
        int          kind;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  op;
        logic [31:0] imm;
        logic [31:0] ins;

        in_if.valid = 1'b0;
        in_if.func = FUNC_EXEC;
        in_if.instruction = '0;
        in_if.mem_address = '0;
        in_if.mem_byte = '0;
        out_if.ready = 1'b0;
        core_pc = '0;
        core_halted = 1'b0;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;

        // directed: immediate extremes, every ALU op, odd function codes
        queue_exec(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd1, OP_I));
        queue_exec(enc_i(12'h800, 5'd0, F3_ADD, 5'd2, OP_I));
        queue_exec(enc_r(F7_ADD, 5'd2, 5'd1, F3_ADD, 5'd3));
        queue_exec(enc_r(F7_SUB, 5'd1, 5'd2, F3_ADD, 5'd4));
        queue_exec(enc_r(F7_MUL, 5'd2, 5'd1, F3_ADD, 5'd5));
        queue_exec(enc_r(F7_ADD, 5'd2, 5'd1, F3_XOR, 5'd6));
        queue_exec(enc_r(F7_SUB, 5'd2, 5'd1, F3_OR, 5'd7));
        queue_exec(enc_r(F7_ADD, 5'd3, 5'd1, F3_AND, 5'd8));
        queue_exec(enc_r(F7_ADD, 5'd3, 5'd1, F3_SRL, 5'd9));
        queue_exec(enc_i(12'h555, 5'd3, F3_XOR, 5'd10, OP_I));
        queue_exec(enc_i(12'h0F0, 5'd2, F3_OR, 5'd11, OP_I));
        queue_exec(enc_i(12'h800, 5'd3, F3_AND, 5'd12, OP_I));
        queue_exec(enc_i(12'h001, 5'd1, F3_SLT, 5'd13, OP_I));
        // memory edges: the last byte, wrap of a word access past the top
        queue_mem(FUNC_PRELOAD, 10'h3FF, 8'hFF);
        queue_mem(FUNC_PRELOAD, 10'h000, 8'hA5);
        queue_exec(enc_i(12'hFFF, 5'd0, F3_WORD, 5'd14, OP_LOAD));
        queue_exec(enc_s(12'hFFE, 5'd4, 5'd0, F3_WORD));
        queue_mem(FUNC_READ, 10'h3FF, 8'h00);
        queue_mem(FUNC_READ, 10'h000, 8'h00);
        // branches: taken, not taken, most negative offset wraps the PC
        queue_exec(enc_b(13'h0008, 5'd1, 5'd1, F3_BEQ));
        queue_exec(enc_b(13'h0008, 5'd1, 5'd1, F3_BNE));
        queue_exec(enc_b(13'h1000, 5'd2, 5'd1, F3_BNE));
        queue_exec(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BLT));
        queue_exec(enc_j(21'h0FFFFE, 5'd1));
        queue_exec(enc_j(21'h100000, 5'd0));
        queue_exec({25'($urandom), OP_UNKNOWN});
        queue_mem(FUNC_UNUSED, 10'($urandom), 8'($urandom));

        repeat (RANDOM_REQS) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                queue_mem(FUNC_PRELOAD, 10'($urandom), 8'($urandom));
            end else if (sel < 22) begin
                queue_mem(FUNC_READ, 10'($urandom), 8'($urandom));
            end else if (sel < 25) begin
                queue_mem(FUNC_UNUSED, 10'($urandom), 8'($urandom));
            end else begin
                rd = pick_reg();
                rs1 = pick_reg();
                rs2 = pick_reg();
                f3 = ($urandom_range(0, 9) < 8) ? ALU_F3S[3*$urandom_range(0, 3) +: 3]
                                                : 3'($urandom);
                imm = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 127)) - 32'd64;
                kind = $urandom_range(0, 99);
                if (kind < 18) begin
                    ins = enc_r(($urandom_range(0, 9) < 9) ?
                                ($urandom_range(0, 1) ? F7_SUB : F7_ADD) : 7'($urandom),
                                rs2, rs1, f3, rd);
                end else if (kind < 36) begin
                    ins = enc_i(imm[11:0], rs1, f3, rd, OP_I);
                end else if (kind < 50) begin
                    ins = enc_i(imm[11:0], rs1, 3'($urandom), rd, OP_LOAD);
                end else if (kind < 64) begin
                    ins = enc_s(imm[11:0], rs2, rs1, 3'($urandom));
                end else if (kind < 78) begin
                    f3 = ($urandom_range(0, 9) < 8) ? ($urandom_range(0, 1) ? F3_BNE : F3_BEQ)
                                                    : 3'($urandom);
                    ins = enc_b(imm[12:0], rs2, rs1, f3);
                end else if (kind < 88) begin
                    ins = enc_j(imm[20:0], rd);
                end else if (kind < 94) begin
                    do op = 7'($urandom);
                    while (op == OP_R || op == OP_I || op == OP_LOAD || op == OP_STORE ||
                           op == OP_BRANCH || op == OP_JAL);
                    ins = {25'($urandom), op};
                end else begin
                    do ins = $urandom;
                    while (ins == HALT_WORD);
                end
                queue_exec(ins);
            end
        end

        // halt last: afterwards execute requests must change nothing, memory access still works
        queue_exec(HALT_WORD);
        queue_exec(enc_s(12'h000, 5'd3, 5'd0, F3_WORD));
        queue_mem(FUNC_READ, 10'h000, 8'h00);
        queue_mem(FUNC_READ, 10'h001, 8'h00);
        queue_exec(enc_i(12'h123, 5'd0, F3_ADD, 5'd1, OP_I));
        queue_mem(FUNC_PRELOAD, 10'h005, 8'h5A);
        queue_mem(FUNC_READ, 10'h005, 8'h00);
        queue_mem(FUNC_UNUSED, 10'h005, 8'h00);
        queue_exec(HALT_WORD);
        n_total = req_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_cnt == n_total && retire_q.size() == 0);
        repeat (12) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rvc_pkg.sv
rtl/rvc_in_if.sv
rtl/rvc_out_if.sv
rtl/rvc_exec.sv
rtl/rvc_dmem.sv
rtl/rv32i_subset_single_cycle_core_top.sv
verif/testbench.sv
